// ===== design/wmod_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmod_pkg
// Shared widths and the control type for the window motion outlier detector.
// ----------------------------------------------------------------------------
package wmod_pkg;

  // Width of one image coordinate.
  localparam int POS_W  = 10;
  // One history word holds x in the upper half and y in the lower half.
  localparam int WORD_W = 2 * POS_W;

  // Controls from the sequencer to each axis unit.
  typedef struct packed {
    logic clear;  // start a new window sum
    logic acc;    // add the sample now on the read port
    logic mul1;   // first product stage
    logic mul2;   // second product stage
  } axis_ctl_t;

endpackage

// ===== design/wmod_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmod_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module wmod_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/wmod_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmod_axis
// Per-axis window statistics: accumulates the sum and the sum of squares of
// the window samples, then tests (N*v - S)^2 >= N*Q - S^2 in two product
// stages.
// ----------------------------------------------------------------------------
module wmod_axis
  import wmod_pkg::*;
#(
  parameter int WIN_LEN = 10
) (
  input  logic             clk,
  input  axis_ctl_t        ctl,
  input  logic [POS_W-1:0] sample,
  input  logic [POS_W-1:0] v,
  output logic             outlier
);

  localparam int CW = $clog2(WIN_LEN + 1);
  localparam int SW = POS_W + CW;
  localparam int QW = 2 * POS_W + CW;
  localparam int VW = 2 * SW;

  logic [SW-1:0]        s;
  logic [QW-1:0]        q;
  logic [2*POS_W-1:0]   sq;
  logic [SW-1:0]        wv;
  logic signed [SW:0]   d;
  logic signed [SW:0]   d_diff;
  logic [VW-1:0]        s2;
  logic [VW-1:0]        wq;
  logic signed [VW+1:0] dd_full;
  logic [VW-1:0]        dd;
  logic [VW-1:0]        var_w;

  // Square of the incoming sample.
  assign sq = (2*POS_W)'(sample) * (2*POS_W)'(sample);

  // Scaled value and its signed offset from the window sum.
  assign wv     = SW'(WIN_LEN) * SW'(v);
  assign d_diff = $signed({1'b0, wv}) - $signed({1'b0, s});

  // Square of the registered offset.
  assign dd_full = (VW+2)'(d) * (VW+2)'(d);

  // Window sum and sum of squares.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      s <= '0;
      q <= '0;
    end else if (ctl.acc) begin
      s <= s + SW'(sample);
      q <= q + QW'(sq);
    end
  end

  // Product stages: the first forms S^2, N*Q and the offset, the second the
  // squared offset and the scaled variance.
  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      d  <= d_diff;
      s2 <= VW'(s) * VW'(s);
      wq <= VW'(WIN_LEN) * VW'(q);
    end
    if (ctl.mul2) begin
      dd    <= dd_full[VW-1:0];
      var_w <= wq - s2;
    end
  end

  assign outlier = (dd >= var_w);

endmodule

// ===== design/window_motion_outlier_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_motion_outlier_detect
// Position history in a RAM with a sliding-window variance outlier test.
// ----------------------------------------------------------------------------
// Sequence: a report that is dropped or leaves the history short goes from
// S_IDLE straight to S_DONE. A report that fills the history passes through
// S_READ, one RAM read a cycle over the window, then the two product stages
// S_MUL1 and S_MUL2 before S_DONE, which registers the result.
// A new transaction is taken only in S_IDLE, so not before the last result is
// registered, and later while the previous result is held back. Reset: rst
// clears the history count, the oldest slot and all handshakes; the RAM contents are not cleared.
module window_motion_outlier_detect
  import wmod_pkg::*;
#(
  parameter int HISTORY_DEPTH = 20,
  parameter int WINDOW_LEN    = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             seen,
  input  logic             from_top,
  input  logic [POS_W-1:0] pos_x,
  input  logic [POS_W-1:0] pos_y,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             moved
);

  localparam int WIN_EFF = (WINDOW_LEN > HISTORY_DEPTH) ? HISTORY_DEPTH : WINDOW_LEN;
  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
  localparam int SUMW = CNTW + 1;
  localparam int IW   = $clog2(WIN_EFF + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL1,
    S_MUL2,
    S_DONE
  } state_t;

  state_t            state;
  logic [CNTW-1:0]   count;
  logic [AW-1:0]     oldest;
  logic [CNTW-1:0]   count_next;
  logic [AW-1:0]     oldest_next;
  logic [CNTW-1:0]   count_base;
  logic [SUMW-1:0]   slot_sum;
  logic [AW-1:0]     wr_slot;
  logic [AW-1:0]     rd_ptr;
  logic [IW-1:0]     iss;
  logic              rd_vld;
  logic              computed;
  logic [POS_W-1:0]  vx;
  logic [POS_W-1:0]  vy;
  logic              accept;
  logic              store;
  logic              rd_en;
  logic [WORD_W-1:0] rd_word;
  logic              out_x;
  logic              out_y;
  axis_ctl_t         ctl;

  assign accept   = in_valid && in_ready;
  assign store    = seen && from_top;
  assign in_ready = (state == S_IDLE);

  // History bookkeeping: drop the oldest entry when full, then append.
  always_comb begin
    if (count == CNTW'(HISTORY_DEPTH)) begin
      oldest_next = (oldest == AW'(HISTORY_DEPTH - 1)) ? '0 : oldest + 1'b1;
      count_base  = CNTW'(HISTORY_DEPTH - 1);
    end else begin
      oldest_next = oldest;
      count_base  = count;
    end
    slot_sum   = SUMW'(oldest_next) + SUMW'(count_base);
    wr_slot    = (slot_sum >= SUMW'(HISTORY_DEPTH)) ?
                 AW'(slot_sum - SUMW'(HISTORY_DEPTH)) : AW'(slot_sum);
    count_next = count_base + 1'b1;
  end

  // Window read issue.
  assign rd_en = (state == S_READ) && (iss != IW'(WIN_EFF));

  wmod_ram #(
    .WIDTH (WORD_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && store),
    .waddr (wr_slot),
    .wdata ({pos_x, pos_y}),
    .re    (rd_en),
    .raddr (rd_ptr),
    .rdata (rd_word)
  );

  // Axis unit controls.
  always_comb begin
    ctl.clear = accept;
    ctl.acc   = (state == S_READ) && rd_vld;
    ctl.mul1  = (state == S_MUL1);
    ctl.mul2  = (state == S_MUL2);
  end

  wmod_axis #(
    .WIN_LEN (WIN_EFF)
  ) u_axis_x (
    .clk     (clk),
    .ctl     (ctl),
    .sample  (rd_word[WORD_W-1:POS_W]),
    .v       (vx),
    .outlier (out_x)
  );

  wmod_axis #(
    .WIN_LEN (WIN_EFF)
  ) u_axis_y (
    .clk     (clk),
    .ctl     (ctl),
    .sample  (rd_word[POS_W-1:0]),
    .v       (vy),
    .outlier (out_y)
  );

  // Sequencer, history state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      oldest    <= '0;
      rd_vld    <= 1'b0;
      iss       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result is cleared unless a new one replaces it this cycle.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      rd_vld <= rd_en;
      case (state)
        S_IDLE: begin
          if (accept) begin
            vx     <= pos_x;
            vy     <= pos_y;
            rd_ptr <= oldest_next;
            iss    <= '0;
            if (store) begin
              count  <= count_next;
              oldest <= oldest_next;
            end
            if (store && (count_next == CNTW'(HISTORY_DEPTH))) begin
              computed <= 1'b1;
              state    <= S_READ;
            end else begin
              computed <= 1'b0;
              state    <= S_DONE;
            end
          end
        end
        S_READ: begin
          if (rd_en) begin
            iss    <= iss + 1'b1;
            rd_ptr <= (rd_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
          end
          // The last sample is accumulated in the cycle that leaves.
          if ((iss == IW'(WIN_EFF)) && rd_vld) begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            moved     <= computed && (out_x || out_y);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/wmod_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmod_checker
// Port-level checks for the window motion outlier detector.
// ----------------------------------------------------------------------------
module wmod_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic moved
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(moved)))
    else $error("stalled result changed");

  // One transaction is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

  // A new result only appears at the end of a busy period.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

endmodule

bind window_motion_outlier_detect wmod_checker u_wmod_checker (.*);
